// File: design/fqs_pkg.sv
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types and constants for the searchable FIFO queue.
// ----------------------------------------------------------------------------
package fqs_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int POS_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic signed [DATA_W-1:0] NONE_VALUE = -1;

   typedef enum logic [2:0] {
      CMD_ENQUEUE = 3'd0,
      CMD_DEQUEUE = 3'd1,
      CMD_FIND    = 3'd2,
      CMD_READ    = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_RANGE     = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

// File: design/fqs_cell.sv
// ----------------------------------------------------------------------------
// fqs_cell
// One queue slot: takes its neighbor's word on a dequeue shift, the
// incoming word on an enqueue load, and compares its word with the key.
// ----------------------------------------------------------------------------
module fqs_cell (
   input  logic                                clock,
   input  fqs_pkg::cell_ctrl_type              ctrl,
   input  logic signed [fqs_pkg::DATA_W-1:0]   load_value,
   input  logic signed [fqs_pkg::DATA_W-1:0]   neighbor_value,
   input  logic signed [fqs_pkg::DATA_W-1:0]   key,
   output logic signed [fqs_pkg::DATA_W-1:0]   value,
   output logic                                hit
);

   logic signed [fqs_pkg::DATA_W-1:0] value_ff;
   logic signed [fqs_pkg::DATA_W-1:0] value_in;

   always_comb begin
      priority if (ctrl.shift) begin
         value_in = neighbor_value;
      end else if (ctrl.load) begin
         value_in = load_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign hit   = (value_ff == key);

endmodule

// File: design/fifo_queue_with_search_core.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_search_core
// Response: registered, appearing in the cycle after its request word
// is accepted. Throughput: one request word per cycle unless a response is
// held under rsp_stall; each cell shifts or loads and compares with the key.
// Reset: synchronous; clears the fill count and the response valid. Cell
// contents are not reset and are only read below the fill count.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_command,
   input  logic signed [31:0]  req_item_value,
   input  logic [4:0]          req_position,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic signed [31:0]  rsp_read_value,
   output logic [3:0]          rsp_found_position,
   output logic [4:0]          rsp_entry_count,
   output logic                rsp_is_empty_flag
);

   localparam int DEPTH = fqs_pkg::DEPTH;
   localparam int POS_W = fqs_pkg::POS_W;
   localparam int CNT_W = fqs_pkg::CNT_W;

   logic                               accept;
   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;
   logic                               enq_ok;
   logic                               deq_ok;
   logic signed [fqs_pkg::DATA_W-1:0]  cell_value [DEPTH];
   logic [DEPTH-1:0]                   cell_hit;
   logic [DEPTH-1:0]                   live_hit;
   fqs_pkg::cell_ctrl_type             cell_ctrl [DEPTH];
   logic [POS_W-1:0]                   found_pos;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   fqs_pkg::status_type                status_ff;
   fqs_pkg::status_type                status_in;
   logic signed [fqs_pkg::DATA_W-1:0]  read_value_ff;
   logic signed [fqs_pkg::DATA_W-1:0]  read_value_in;
   logic [POS_W-1:0]                   found_ff;
   logic [POS_W-1:0]                   found_in;
   logic [CNT_W-1:0]                   count_out_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic signed [fqs_pkg::DATA_W-1:0] nbr;
         if (gi == DEPTH - 1) begin : g_last
            assign nbr = cell_value[gi];
         end else begin : g_mid
            assign nbr = cell_value[gi+1];
         end
         assign cell_ctrl[gi].shift = deq_ok;
         assign cell_ctrl[gi].load  = enq_ok & (count_ff == CNT_W'(gi));
         assign live_hit[gi]        = cell_hit[gi] & (CNT_W'(gi) < count_ff);
         fqs_cell u_cell (
            .clock          (clock),
            .ctrl           (cell_ctrl[gi]),
            .load_value     (req_item_value),
            .neighbor_value (nbr),
            .key            (req_item_value),
            .value          (cell_value[gi]),
            .hit            (cell_hit[gi])
         );
      end
   endgenerate

   always_comb begin
      found_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (live_hit[i]) begin
            found_pos = POS_W'(i);
         end
      end
   end

   always_comb begin
      enq_ok        = 1'b0;
      deq_ok        = 1'b0;
      count_in      = count_ff;
      status_in     = fqs_pkg::ST_OK;
      found_in      = '0;
      read_value_in = (count_ff != '0) ? cell_value[0] : fqs_pkg::NONE_VALUE;
      if (accept) begin
         unique case (fqs_pkg::cmd_type'(req_command))
            fqs_pkg::CMD_ENQUEUE: begin
               if (count_ff >= CNT_W'(DEPTH)) begin
                  status_in = fqs_pkg::ST_FULL;
               end else begin
                  enq_ok   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            fqs_pkg::CMD_DEQUEUE: begin
               if (count_ff == '0) begin
                  status_in = fqs_pkg::ST_EMPTY;
               end else begin
                  deq_ok   = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            fqs_pkg::CMD_FIND: begin
               if (|live_hit) begin
                  found_in = found_pos;
               end else begin
                  status_in = fqs_pkg::ST_NOT_FOUND;
               end
            end
            fqs_pkg::CMD_READ: begin
               if (CNT_W'(req_position) < count_ff) begin
                  read_value_in = cell_value[req_position[POS_W-1:0]];
               end else begin
                  status_in     = fqs_pkg::ST_RANGE;
                  read_value_in = fqs_pkg::NONE_VALUE;
               end
            end
            fqs_pkg::CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         read_value_ff <= read_value_in;
         found_ff      <= found_in;
         count_out_ff  <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_read_value     = read_value_ff;
   assign rsp_found_position = found_ff;
   assign rsp_entry_count    = count_out_ff;
   assign rsp_is_empty_flag  = (count_out_ff == '0);

endmodule

// File: design/fqs_checker.sv
// ----------------------------------------------------------------------------
// fqs_checker
// Port-level checks for the searchable FIFO queue, bound to the top level.
// ----------------------------------------------------------------------------
module fqs_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [2:0]          rsp_status,
   input logic signed [31:0]  rsp_read_value,
   input logic [4:0]          rsp_entry_count,
   input logic                rsp_is_empty_flag
);

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty_flag == (rsp_entry_count == 5'd0)))
      else $error("empty flag disagrees with entry count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= 5'(fqs_pkg::DEPTH)))
      else $error("entry count above depth");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held response");

   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request produced no response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_read_value)))
      else $error("stalled response changed");

endmodule

bind fifo_queue_with_search_core fqs_checker u_fqs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_read_value    (rsp_read_value),
   .rsp_entry_count   (rsp_entry_count),
   .rsp_is_empty_flag (rsp_is_empty_flag)
);

// File: tb/fqs_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqs_queue_checker
// Watches the request and response channels of the searchable FIFO queue,
// keeps its own copy of the ring contents, head and fill count, works out
// the response to every accepted request word and compares each accepted
// response word, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fqs_queue_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [2:0]          req_command,
   input  logic signed [31:0]  req_item_value,
   input  logic [4:0]          req_position,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [2:0]          rsp_status,
   input  logic signed [31:0]  rsp_read_value,
   input  logic [3:0]          rsp_found_position,
   input  logic [4:0]          rsp_entry_count,
   input  logic                rsp_is_empty_flag,
   output int                  mismatch_count,
   output int                  pending_count,
   output int                  answers_checked,
   output logic [4:0]          status_seen
);

   typedef struct {
      fqs_pkg::status_type                       status;
      logic signed [fqs_pkg::DATA_W-1:0]         read_value;
      logic [fqs_pkg::POS_W-1:0]                 found_position;
      logic [fqs_pkg::CNT_W-1:0]                 entry_count;
      logic                                      empty_flag;
   } answer_type;

   logic signed [fqs_pkg::DATA_W-1:0] slots [fqs_pkg::DEPTH];
   int                                head;
   int                                fill;
   answer_type                        pending_answers [$];

   function automatic int ring(input int offset);
      return (head + offset) % fqs_pkg::DEPTH;
   endfunction

   // apply one command to the shadow queue and return the response it yields
   function automatic answer_type advance_queue(input logic [2:0] cmd,
                                                input logic signed [31:0] key,
                                                input logic [4:0] pos);
      answer_type a;
      a.status         = fqs_pkg::ST_OK;
      a.read_value     = (fill != 0) ? slots[head] : fqs_pkg::NONE_VALUE;
      a.found_position = '0;
      unique case (cmd)
         fqs_pkg::CMD_ENQUEUE: begin
            if (fill >= fqs_pkg::DEPTH) begin
               a.status = fqs_pkg::ST_FULL;
            end else begin
               slots[ring(fill)] = key;
               fill++;
            end
         end
         fqs_pkg::CMD_DEQUEUE: begin
            if (fill == 0) begin
               a.status = fqs_pkg::ST_EMPTY;
            end else begin
               head = ring(1);
               fill--;
            end
         end
         fqs_pkg::CMD_FIND: begin
            a.status = fqs_pkg::ST_NOT_FOUND;
            for (int i = 0; i < fill; i++) begin
               if (slots[ring(i)] == key) begin
                  a.status         = fqs_pkg::ST_OK;
                  a.found_position = fqs_pkg::POS_W'(i);
                  break;
               end
            end
         end
         fqs_pkg::CMD_READ: begin
            if (pos < fill) begin
               a.read_value = slots[ring(pos)];
            end else begin
               a.status     = fqs_pkg::ST_RANGE;
               a.read_value = fqs_pkg::NONE_VALUE;
            end
         end
         fqs_pkg::CMD_CLEAR: begin
            head = 0;
            fill = 0;
         end
         default: ;
      endcase
      a.entry_count = fqs_pkg::CNT_W'(fill);
      a.empty_flag  = (fill == 0);
      return a;
   endfunction

   task automatic note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         head            = 0;
         fill            = 0;
         mismatch_count  = 0;
         answers_checked = 0;
         status_seen     = '0;
         pending_answers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            answers_checked++;
            if (rsp_status <= fqs_pkg::ST_FULL) begin
               status_seen[rsp_status] = 1'b1;
            end
            if (pending_answers.size() == 0) begin
               note_failure("response word with no request outstanding");
            end else begin
               want = pending_answers.pop_front();
               if (want.status !== rsp_status || want.read_value !== rsp_read_value ||
                   want.found_position !== rsp_found_position ||
                   want.entry_count !== rsp_entry_count ||
                   want.empty_flag !== rsp_is_empty_flag) begin
                  note_failure($sformatf({"mismatch: expected status %0d value %0d ",
                     "pos %0d count %0d empty %0b, got %0d %0d %0d %0d %0b"},
                     want.status, want.read_value, want.found_position,
                     want.entry_count, want.empty_flag, rsp_status, rsp_read_value,
                     rsp_found_position, rsp_entry_count, rsp_is_empty_flag));
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_answers.insert(pending_answers.size(),
                                   advance_queue(req_command, req_item_value,
                                                 req_position));
         end
      end
      pending_count = pending_answers.size();
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the searchable FIFO queue with a directed opening (empty queue,
// extreme values, duplicate search keys, reads past the count, unused
// command codes, clear) and then runs of fill-heavy, balanced and
// drain-heavy random command words under three pacing phases, a long
// response hold-off and drain pauses. A checker module predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

   localparam int         LIMIT          = 200000;
   localparam int         PHASE_WORDS    = 400;
   localparam int         MODE_FILL      = 0;
   localparam int         MODE_MIX       = 1;
   localparam int         MODE_DRAIN     = 2;
   localparam logic [2:0] UNUSED_CMD_LO  = 3'd5;
   localparam logic [2:0] UNUSED_CMD_MID = 3'd6;
   localparam logic [2:0] UNUSED_CMD_HI  = 3'd7;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [2:0]          req_command;
   logic signed [31:0]  req_item_value;
   logic [4:0]          req_position;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [2:0]          rsp_status;
   logic signed [31:0]  rsp_read_value;
   logic [3:0]          rsp_found_position;
   logic [4:0]          rsp_entry_count;
   logic                rsp_is_empty_flag;

   int                  mismatch_count;
   int                  pending_count;
   int                  answers_checked;
   logic [4:0]          status_seen;

   int                  req_idle_pct = 0;
   int                  rsp_idle_pct = 0;
   logic                hold_go = 1'b0;
   int                  cycle_count = 0;
   int                  words_sent = 0;
   logic [31:0]         recent_values [8];
   int                  recent_next = 0;

   fifo_queue_with_search_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_item_value     (req_item_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_is_empty_flag  (rsp_is_empty_flag)
   );

   fqs_queue_checker i_queue_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_item_value     (req_item_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_is_empty_flag  (rsp_is_empty_flag),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .answers_checked    (answers_checked),
      .status_seen        (status_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // response side: random stall, plus one long hold-off counted here
   initial begin
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_used) begin
            hold_used = 1'b1;
            hold_left = 60;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input logic [2:0] cmd, input logic [31:0] value,
                            input logic [4:0] pos);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_item_value <= value;
      req_position   <= pos;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic send_random(input int mode);
      int          pick;
      int          enq_pct;
      int          deq_pct;
      logic [2:0]  cmd;
      logic [31:0] value;
      logic [4:0]  pos;
      case (mode)
         MODE_FILL: begin
            enq_pct = 70;
            deq_pct = 10;
         end
         MODE_DRAIN: begin
            enq_pct = 10;
            deq_pct = 65;
         end
         default: begin
            enq_pct = 35;
            deq_pct = 30;
         end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 2) cmd = fqs_pkg::CMD_CLEAR;
      else if (pick < 5) cmd = 3'($urandom_range(UNUSED_CMD_LO, UNUSED_CMD_HI));
      else if (pick < 5 + enq_pct) cmd = fqs_pkg::CMD_ENQUEUE;
      else if (pick < 5 + enq_pct + deq_pct) cmd = fqs_pkg::CMD_DEQUEUE;
      else if (pick % 2 == 0) cmd = fqs_pkg::CMD_FIND;
      else cmd = fqs_pkg::CMD_READ;

      // small values give duplicates, so a search must pick the first match
      if ($urandom_range(0, 3) == 0) value = $urandom_range(0, 7);
      else value = $urandom;
      if (cmd == fqs_pkg::CMD_FIND && $urandom_range(0, 99) < 70) begin
         value = recent_values[$urandom_range(0, 7)];
      end
      if (cmd == fqs_pkg::CMD_ENQUEUE) begin
         recent_values[recent_next] = value;
         recent_next = (recent_next + 1) % 8;
      end
      if ($urandom_range(0, 4) == 0) pos = 5'($urandom_range(0, 31));
      else pos = 5'($urandom_range(0, fqs_pkg::DEPTH));
      send_word(cmd, value, pos);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = fqs_pkg::CMD_ENQUEUE;
      req_item_value = '0;
      req_position   = '0;
      foreach (recent_values[i]) recent_values[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty queue
      send_word(fqs_pkg::CMD_DEQUEUE, 32'h0000_0000, 5'd0);
      send_word(fqs_pkg::CMD_FIND, 32'h0000_0000, 5'd0);
      send_word(fqs_pkg::CMD_READ, 32'hFFFF_FFFF, 5'd0);
      send_word(UNUSED_CMD_LO, 32'h0000_0001, 5'd1);
      // extremes and a duplicate
      send_word(fqs_pkg::CMD_ENQUEUE, 32'h8000_0000, 5'd0);
      send_word(fqs_pkg::CMD_ENQUEUE, 32'h7FFF_FFFF, 5'd31);
      send_word(fqs_pkg::CMD_ENQUEUE, 32'h0000_0000, 5'd0);
      send_word(fqs_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 5'd31);
      send_word(fqs_pkg::CMD_ENQUEUE, 32'h5555_5555, 5'd0);
      send_word(fqs_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 5'd0);
      send_word(fqs_pkg::CMD_FIND, 32'hFFFF_FFFF, 5'd0);
      send_word(fqs_pkg::CMD_FIND, 32'h1234_5678, 5'd0);
      send_word(fqs_pkg::CMD_READ, 32'h0000_0000, 5'd0);
      send_word(fqs_pkg::CMD_READ, 32'h0000_0000, 5'd5);
      send_word(fqs_pkg::CMD_READ, 32'h0000_0000, 5'd6);
      send_word(fqs_pkg::CMD_READ, 32'hAAAA_AAAA, 5'd31);
      send_word(UNUSED_CMD_MID, 32'h0000_0000, 5'd0);
      send_word(UNUSED_CMD_HI, 32'h0000_0000, 5'd0);
      send_word(fqs_pkg::CMD_DEQUEUE, 32'h0000_0000, 5'd0);
      send_word(fqs_pkg::CMD_CLEAR, 32'h0000_0000, 5'd0);
      send_word(fqs_pkg::CMD_DEQUEUE, 32'h0000_0000, 5'd0);
      send_word(fqs_pkg::CMD_READ, 32'h0000_0000, 5'd16);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 9;
               rsp_idle_pct = 53;
            end
            1: begin
               req_idle_pct = 53;
               rsp_idle_pct = 9;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
               hold_go <= 1'b1;
            end
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_random((n / 40) % 3);
            if (n % 150 == 149) wait_drained();
         end
         wait_drained();
      end

      repeat (4) @(posedge clock);
      $display("Summary: %0d request words sent over three pacing phases with a long hold-off",
               words_sent);
      $display("Summary: %0d responses checked, status codes seen (4..0) %b",
               answers_checked, status_seen);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
